// ===== rtl/ftn_pkg.sv =====
// Shared types, constants and arithmetic helpers for the frequency to note number unit.
// No dependencies; every other file imports this package.
package ftn_pkg;

    localparam int LOG_FB     = 32;                    // fraction bits of the log2 values
    localparam int LOG_INT_W  = 5;                     // integer bits of the log2 values
    localparam int LOG_W      = LOG_INT_W + LOG_FB;
    localparam int DIFF_W     = LOG_W + 1;
    localparam int PROD_W     = 48;
    localparam int STEP_W     = $clog2(LOG_FB);
    localparam int NOTE_OFFSET   = 69;
    localparam int SENTINEL_MAG  = 1500;
    localparam int ADDR_W     = 3;

    localparam logic [31:0] RESET_REF   = 32'd28835840;
    localparam logic [7:0]  RESET_TONES = 8'd12;

    // register index, taken from paddr[2]
    localparam logic REG_REF   = 1'b0;
    localparam logic REG_TONES = 1'b1;

    typedef logic signed [31:0] freq_t;
    typedef logic signed [31:0] note_t;
    typedef logic [LOG_W-1:0]   log_t;

    typedef struct packed {
        logic [LOG_INT_W-1:0] p;
        logic [31:0]          m;
    } norm_t;

    typedef struct packed {
        logic        carry;
        logic [31:0] m;
    } sq_t;

    typedef struct packed {
        logic valid;
        logic pos;
        log_t log_val;
    } log_beat_t;

    typedef struct packed {
        logic  valid;
        note_t note;
        logic  pitch_valid;
    } note_beat_t;

    // leading-one position and mantissa normalized to [2^31, 2^32)
    function automatic norm_t lead_norm(input logic [31:0] x);
        norm_t r;
        r.p = '0;
        for (int i = 0; i < 32; i++) begin
            if (x[i]) begin
                r.p = LOG_INT_W'(i);
            end
        end
        r.m = x << (LOG_INT_W'(31) - r.p);
        return r;
    endfunction

    // one squaring step of the log2 fraction refinement
    function automatic sq_t sq_step(input logic [31:0] m);
        logic [63:0] prod;
        logic [32:0] t;
        sq_t         r;
        prod    = {32'd0, m} * {32'd0, m};
        t       = prod[63:31];
        r.carry = t[32];
        r.m     = t[32] ? t[32:1] : t[31:0];
        return r;
    endfunction

    // -1500 in Q.fb, clamped to the 32-bit range
    function automatic note_t sentinel_note(input int unsigned fb);
        longint s;
        longint lim;
        lim = -(64'sd1 <<< 31);
        s   = -(longint'(SENTINEL_MAG) <<< fb);
        return (s < lim) ? note_t'(32'h8000_0000) : note_t'(s[31:0]);
    endfunction

endpackage

// ===== rtl/ftn_freq_if.sv =====
// Input channel: one frequency per transaction, valid/ready handshake.
// Depends on ftn_pkg.
interface ftn_freq_if import ftn_pkg::*; ();
    logic  valid;
    logic  ready;
    freq_t frequency;

    modport source (output valid, output frequency, input ready);
    modport sink   (input valid, input frequency, output ready);
endinterface

// ===== rtl/ftn_note_if.sv =====
// Output channel: one note number and pitch flag per transaction, valid/ready handshake.
// Depends on ftn_pkg.
interface ftn_note_if import ftn_pkg::*; ();
    logic  valid;
    logic  ready;
    note_t note_number;
    logic  pitch_valid;

    modport source (output valid, output note_number, output pitch_valid, input ready);
    modport sink   (input valid, input note_number, input pitch_valid, output ready);
endinterface

// ===== rtl/frequency_to_note_number_unit.sv =====
// Top level of the frequency to note number unit: config registers, reference log
// engine, log2 pipeline, note arithmetic and output buffer.
// Depends on ftn_pkg, ftn_freq_if, ftn_note_if and the ftn_* submodules.
//
//  channel    dir  handshake         payload
//  freq_in    in   valid/ready       frequency      (signed Q16.16 Hz)
//  note_out   out  valid/ready       note_number, pitch_valid
//  APB        in   psel/penable      reference_freq @0x0, tones_per_octave @0x4
//
// One transaction per cycle in steady state, while the output buffer has space
// and the reference log is idle; the log2 pipeline has 32 squaring stages, one
// 32x32 multiplier each. After reset and after each reference_freq write (write
// cycle included), freq_in.ready stays low while the single multiplier of the
// reference log engine iterates log2 of the reference.
// A stall on note_out freezes the pipeline only once the two-entry output
// buffer is full; no transaction is dropped or repeated.
module frequency_to_note_number_unit import ftn_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    ftn_freq_if.sink          freq_in,
    ftn_note_if.source        note_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [31:0] reference_freq_reg;
    logic [7:0]  tones_per_octave_reg;

    logic       cfg_wr;
    logic       ref_wr;
    logic       ref_busy;
    log_t       log_ref;
    logic       pipe_en;
    logic       take;
    log_beat_t  log_beat;
    note_beat_t note_beat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign ref_wr = cfg_wr && (paddr[2] == REG_REF);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            reference_freq_reg   <= RESET_REF;
            tones_per_octave_reg <= RESET_TONES;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_REF:   reference_freq_reg   <= pwdata;
                REG_TONES: tones_per_octave_reg <= pwdata[7:0];
                default:   reference_freq_reg   <= reference_freq_reg;
            endcase
        end
    end

    assign prdata = (paddr[2] == REG_TONES) ? {24'd0, tones_per_octave_reg}
                                            : reference_freq_reg;

    assign freq_in.ready = pipe_en && !ref_busy && !ref_wr;
    assign take          = freq_in.valid && freq_in.ready;

    ftn_ref_log u_ref_log (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (ref_wr),
        .ref_value (reference_freq_reg),
        .busy      (ref_busy),
        .log_ref   (log_ref)
    );

    ftn_log2_pipe u_log2_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .take      (take),
        .frequency (freq_in.frequency),
        .out_beat  (log_beat)
    );

    ftn_scale #(
        .FRAC_BITS (FRAC_BITS)
    ) u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_en),
        .in_beat  (log_beat),
        .log_ref  (log_ref),
        .tones    (tones_per_octave_reg),
        .out_beat (note_beat)
    );

    ftn_out_buf u_out_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_beat  (note_beat),
        .en       (pipe_en),
        .note_out (note_out)
    );

    a_no_take_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ref_busy |-> !freq_in.ready)
        else $error("input ready while reference log is being computed");

    a_ref_write_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        ref_wr |=> (ref_busy && !freq_in.ready))
        else $error("reference write did not start the reference log engine");

    a_sentinel: assert property (@(posedge clk) disable iff (!rst_n)
        (note_out.valid && !note_out.pitch_valid) |->
            (note_out.note_number == sentinel_note(FRAC_BITS)))
        else $error("non-positive frequency result is not the sentinel");

endmodule

// ===== rtl/ftn_log2_pipe.sv =====
// Pipelined fixed-point log2 of the input frequency: normalize stage plus one
// squaring stage per fraction bit. Depends on ftn_pkg.
module ftn_log2_pipe import ftn_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      take,
    input  freq_t     frequency,
    output log_beat_t out_beat
);

    localparam int NST = LOG_FB;

    logic [NST:0]         v_reg;
    logic                 pos_reg [0:NST];
    logic [LOG_INT_W-1:0] p_reg   [0:NST];
    logic [31:0]          m_reg   [0:NST];
    logic [31:0]          f_reg   [1:NST];

    logic        pos_in;
    norm_t       norm_in;
    sq_t         sq_res  [1:NST];
    logic [31:0] f_prev  [1:NST];

    always_comb
    begin
        pos_in  = !frequency[31] && (frequency != '0);
        norm_in = lead_norm(pos_in ? frequency : 32'd1);
        for (int k = 1; k <= NST; k++) begin
            sq_res[k] = sq_step(m_reg[k-1]);
            f_prev[k] = (k == 1) ? 32'd0 : f_reg[(k == 1) ? 1 : k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NST-1:0], take};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            pos_reg[0] <= pos_in;
            p_reg[0]   <= norm_in.p;
            m_reg[0]   <= norm_in.m;
            for (int k = 1; k <= NST; k++) begin
                pos_reg[k] <= pos_reg[k-1];
                p_reg[k]   <= p_reg[k-1];
                m_reg[k]   <= sq_res[k].m;
                f_reg[k]   <= {f_prev[k][30:0], sq_res[k].carry};
            end
        end
    end

    assign out_beat.valid   = v_reg[NST];
    assign out_beat.pos     = pos_reg[NST];
    assign out_beat.log_val = {p_reg[NST], f_reg[NST]};

endmodule

// ===== rtl/ftn_ref_log.sv =====
// Sequential log2 of the reference pitch, one squaring step per cycle on a
// single multiplier; reruns after reset and after each reference write. Depends on ftn_pkg.
module ftn_ref_log import ftn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] ref_value,
    output logic        busy,
    output log_t        log_ref
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_NORM,
        ST_SQUARE
    } state_t;

    state_t               state_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [LOG_INT_W-1:0] p_reg;
    logic [31:0]          m_reg;
    logic [31:0]          f_reg;
    log_t                 log_ref_reg;

    norm_t       norm_ref;
    sq_t         sq_res;
    logic [31:0] f_next;

    always_comb
    begin
        norm_ref = lead_norm((ref_value == '0) ? 32'd1 : ref_value);
        sq_res   = sq_step(m_reg);
        f_next   = {f_reg[30:0], sq_res.carry};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg   <= ST_NORM;
            step_reg    <= '0;
            p_reg       <= '0;
            m_reg       <= '0;
            f_reg       <= '0;
            log_ref_reg <= '0;
        end else if (start) begin
            state_reg <= ST_NORM;
        end else begin
            case (state_reg)
                ST_NORM:
                begin
                    p_reg     <= norm_ref.p;
                    m_reg     <= norm_ref.m;
                    f_reg     <= '0;
                    step_reg  <= '0;
                    state_reg <= ST_SQUARE;
                end
                ST_SQUARE:
                begin
                    m_reg    <= sq_res.m;
                    f_reg    <= f_next;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(LOG_FB - 1)) begin
                        log_ref_reg <= {p_reg, f_next};
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy    = (state_reg != ST_IDLE);
    assign log_ref = log_ref_reg;

endmodule

// ===== rtl/ftn_scale.sv =====
// Note arithmetic: log difference, scale by tones per octave, offset,
// round half up and saturate, in three register stages. Depends on ftn_pkg.
module ftn_scale import ftn_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  log_beat_t  in_beat,
    input  log_t       log_ref,
    input  logic [7:0] tones,
    output note_beat_t out_beat
);

    localparam int SH = LOG_FB - FRAC_BITS;
    localparam logic signed [PROD_W-1:0] ADD_C =
        (PROD_W'(NOTE_OFFSET) <<< LOG_FB) + (PROD_W'(1) <<< (SH - 1));
    localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'(32'sh7fff_ffff);
    localparam logic signed [PROD_W-1:0] SAT_MIN = -(PROD_W'(1) <<< 31);
    localparam note_t SENTINEL = sentinel_note(FRAC_BITS);

    logic [2:0]                 v_reg;
    logic                       pos_a_reg;
    logic                       pos_b_reg;
    logic signed [DIFF_W-1:0]   diff_a_reg;
    logic signed [PROD_W-1:0]   prod_b_reg;
    note_t                      note_c_reg;
    logic                       pv_c_reg;

    logic signed [DIFF_W-1:0] diff_next;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] sum_c;
    logic signed [PROD_W-1:0] rnd_c;
    logic signed [8:0]        tones_s;
    note_t                    note_next;

    always_comb
    begin
        diff_next = $signed({1'b0, in_beat.log_val}) - $signed({1'b0, log_ref});
        tones_s   = $signed({1'b0, tones});
        prod_next = PROD_W'(diff_a_reg) * tones_s;
        sum_c     = prod_b_reg + ADD_C;
        rnd_c     = sum_c >>> SH;
        if (!pos_b_reg) begin
            note_next = SENTINEL;
        end else if (rnd_c > SAT_MAX) begin
            note_next = note_t'(32'h7fff_ffff);
        end else if (rnd_c < SAT_MIN) begin
            note_next = note_t'(32'h8000_0000);
        end else begin
            note_next = rnd_c[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[1:0], in_beat.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            pos_a_reg  <= in_beat.pos;
            diff_a_reg <= diff_next;
            pos_b_reg  <= pos_a_reg;
            prod_b_reg <= prod_next;
            note_c_reg <= note_next;
            pv_c_reg   <= pos_b_reg;
        end
    end

    assign out_beat.valid       = v_reg[2];
    assign out_beat.note        = note_c_reg;
    assign out_beat.pitch_valid = pv_c_reg;

endmodule

// ===== rtl/ftn_out_buf.sv =====
// Two-entry output buffer; its free space is the advance enable of the
// whole pipeline. Depends on ftn_pkg and ftn_note_if.
module ftn_out_buf import ftn_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  note_beat_t        in_beat,
    output logic              en,
    ftn_note_if.source        note_out
);

    localparam int DEPTH = 2;

    logic [1:0] count_reg;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    note_t      note_mem [0:DEPTH-1];
    logic       pv_mem   [0:DEPTH-1];

    logic push;
    logic pop;

    assign en   = (count_reg != 2'(DEPTH));
    assign push = in_beat.valid && en;
    assign pop  = note_out.valid && note_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            note_mem[wr_ptr_reg] <= in_beat.note;
            pv_mem[wr_ptr_reg]   <= in_beat.pitch_valid;
        end
    end

    assign note_out.valid       = (count_reg != '0);
    assign note_out.note_number = note_mem[rd_ptr_reg];
    assign note_out.pitch_valid = pv_mem[rd_ptr_reg];

endmodule

// ===== dv/ftn_tb_pkg.sv =====
`timescale 1ns / 1ps
// Scoreboard for the frequency to note number unit: bit-exact note prediction
// and in-order result checking. Depends on ftn_pkg.
package ftn_tb_pkg;
    import ftn_pkg::*;

    localparam int     TB_FRAC_BITS = 16;
    localparam int     ROUND_SHIFT  = LOG_FB - TB_FRAC_BITS;
    localparam longint NOTE_MAX     = 64'sd2147483647;
    localparam longint NOTE_MIN     = -64'sd2147483648;

    typedef struct {
        note_t note;
        logic  pitch_valid;
    } note_result_t;

    class note_scoreboard;
        logic [31:0]  ref_freq;
        logic [7:0]   tones;
        note_result_t expected_notes[$];
        int           mismatches;
        int           checked;
        int           nonpositive;

        function new();
            ref_freq    = RESET_REF;
            tones       = RESET_TONES;
            mismatches  = 0;
            checked     = 0;
            nonpositive = 0;
        endfunction

        function void set_reg(logic idx, logic [31:0] value);
            if (idx == REG_REF)
                ref_freq = value;
            else
                tones = value[7:0];
        endfunction

        // log2 with 5 integer and 32 fraction bits
        function logic [36:0] log2_q32(logic [31:0] x);
            logic [4:0]  msb;
            logic [63:0] mant;
            logic [31:0] frac;
            msb = '0;
            for (int i = 0; i < 32; i++)
                if (x[i])
                    msb = 5'(i);
            mant = {32'd0, x} << (31 - msb);
            frac = '0;
            for (int k = 0; k < 32; k++)
            begin
                mant = (mant * mant) >> 31;
                frac = {frac[30:0], mant[32]};
                if (mant[32])
                    mant = mant >> 1;
            end
            return {msb, frac};
        endfunction

        function note_result_t predict_note(freq_t f);
            note_result_t r;
            logic [31:0]  rf;
            longint       acc;
            if (f <= 0)
            begin
                acc = -(longint'(SENTINEL_MAG) <<< TB_FRAC_BITS);
                r.pitch_valid = 1'b0;
            end
            else
            begin
                rf  = (ref_freq == 0) ? 32'd1 : ref_freq;
                acc = longint'(log2_q32(f)) - longint'(log2_q32(rf));
                acc = acc * longint'(tones) + (longint'(NOTE_OFFSET) <<< LOG_FB);
                acc = (acc + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
                r.pitch_valid = 1'b1;
            end
            if (acc > NOTE_MAX)
                acc = NOTE_MAX;
            else if (acc < NOTE_MIN)
                acc = NOTE_MIN;
            r.note = acc[31:0];
            return r;
        endfunction

        function void add_frequency(freq_t f);
            if (f <= 0)
                nonpositive++;
            expected_notes.push_back(predict_note(f));
        endfunction

        function void check_note(note_t note, logic pv);
            note_result_t e;
            checked++;
            if (expected_notes.size() == 0)
            begin
                $error("note_number: expected none, got %0d", note);
                mismatches++;
                return;
            end
            e = expected_notes.pop_front();
            if (note !== e.note)
            begin
                $error("note_number: expected %0d, got %0d", e.note, note);
                mismatches++;
            end
            if (pv !== e.pitch_valid)
            begin
                $error("pitch_valid: expected %0b, got %0b", e.pitch_valid, pv);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_notes.size();
        endfunction
    endclass

endpackage

// ===== dv/frequency_to_note_number_unit_tb.sv =====
`timescale 1ns / 1ps
// Top-level testbench of the frequency to note number unit: APB setup, bursty
// frequency stimulus, stalling receiver. Depends on ftn_pkg, ftn_tb_pkg, the interfaces.
module frequency_to_note_number_unit_tb;
    import ftn_pkg::*;
    import ftn_tb_pkg::*;

    localparam int DRAIN_CYCLES = 48;
    localparam int PHASE_ITEMS  = 220;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    int                hold_cycles;
    int                stall_mode;
    int                reg_writes;
    note_scoreboard    sb;

    ftn_freq_if freq_ch ();
    ftn_note_if note_ch ();

    frequency_to_note_number_unit #(.FRAC_BITS(TB_FRAC_BITS)) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .freq_in  (freq_ch),
        .note_out (note_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic write_reg(logic idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, value);
        reg_writes++;
        @(posedge clk);
    endtask

    task automatic send_freq(freq_t f);
        freq_ch.valid     <= 1'b1;
        freq_ch.frequency <= f;
        @(posedge clk);
        while (!freq_ch.ready)
            @(posedge clk);
        sb.add_frequency(f);
    endtask

    task automatic idle_freq(int cycles);
        freq_ch.valid <= 1'b0;
        repeat (cycles)
            @(posedge clk);
    endtask

    // sender pauses until every result is back, then lets the pipeline settle
    task automatic drain_notes();
        freq_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    function automatic freq_t rand_freq();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0: v = $urandom;
            1: v = ($urandom_range(0, 3) == 0) ? 32'd0 : ($urandom | 32'h8000_0000);
            2, 3: v = ($urandom_range(20, 20000) << 16) | $urandom_range(0, 65535);
            4: v = $urandom >> $urandom_range(1, 31);
            5: v = (32'd1 << $urandom_range(0, 30)) + $urandom_range(0, 2) - 1;
            6: v = sb.ref_freq + $urandom_range(0, 511) - 256;
            default: v = $urandom & 32'h7FFF_FFFF;
        endcase
        return freq_t'(v);
    endfunction

    task automatic run_bursts(int items);
        int sent;
        int burst;
        sent = 0;
        while (sent < items)
        begin
            burst = $urandom_range(1, 40);
            for (int i = 0; i < burst && sent < items; i++)
            begin
                send_freq(rand_freq());
                sent++;
            end
            if ($urandom_range(0, 9) < 7)
                idle_freq($urandom_range(1, 8));
        end
    endtask

    // receiver: checks accepted transactions and stalls per the current mode
    initial
    begin
        note_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (note_ch.valid === 1'b1 && note_ch.ready)
                sb.check_note(note_ch.note_number, note_ch.pitch_valid);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                note_ch.ready <= 1'b0;
            end
            else
            begin
                case (stall_mode)
                    0: note_ch.ready <= 1'b1;
                    1: note_ch.ready <= ($urandom_range(0, 3) != 0);
                    2: note_ch.ready <= ($urandom_range(0, 9) < 3);
                    default: note_ch.ready <= (($urandom_range(0, 4)) >= 2);
                endcase
            end
        end
    end

    initial
    begin
        stall_mode = 0;
        forever
        begin
            repeat ($urandom_range(50, 300))
                @(posedge clk);
            stall_mode = $urandom_range(0, 3);
        end
    end

    initial
    begin
        #(700_000 * 8);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        logic [31:0] cfg_ref[9];
        logic [7:0]  cfg_tones[9];
        freq_t       directed[20];

        sb          = new();
        hold_cycles = 0;
        reg_writes  = 0;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        freq_ch.valid     = 1'b0;
        freq_ch.frequency = '0;

        cfg_ref   = '{RESET_REF, 32'h0001_0000, 32'hFFFF_FFFF, 32'd0, 32'h0001_0000,
                      32'hFFFF_FFFF, $urandom, RESET_REF, $urandom};
        cfg_tones = '{RESET_TONES, 8'd1, 8'd255, 8'd0, 8'd255, 8'd1,
                      8'($urandom), 8'd19, 8'($urandom)};
        directed  = '{32'sd0, -32'sd1, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd1, 32'sd2,
                      32'sd3, 32'sh0001_0000, 32'sd28835840, 32'sd57671680,
                      32'sd14417920, 32'sh8000_0001, 32'shFFFF_0000, 32'sh0000_8000,
                      32'sh4000_0000, 32'sh0000_FFFF, 32'sh0001_0001, 32'sh5555_5555,
                      32'sh2AAA_AAAA, 32'sh7FFF_0000};

        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed transactions at the reset setting, back to back
        foreach (directed[i])
            send_freq(directed[i]);
        drain_notes();

        foreach (cfg_ref[p])
        begin
            write_reg(REG_REF, cfg_ref[p]);
            write_reg(REG_TONES, {24'd0, cfg_tones[p]});
            if (p == 2)
                hold_cycles = 400;
            run_bursts(PHASE_ITEMS / 2);
            if (p % 2 == 1)
                drain_notes();
            run_bursts(PHASE_ITEMS / 2);
            drain_notes();
        end

        $display("Covered %0d conversions, %0d with non-positive frequency, across %0d",
                 sb.checked, sb.nonpositive, reg_writes);
        $display("register writes incl. zero and full-scale reference and tone extremes.");
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ftn_pkg.sv
rtl/ftn_freq_if.sv
rtl/ftn_note_if.sv
rtl/ftn_log2_pipe.sv
rtl/ftn_ref_log.sv
rtl/ftn_scale.sv
rtl/ftn_out_buf.sv
rtl/frequency_to_note_number_unit.sv
dv/ftn_tb_pkg.sv
dv/frequency_to_note_number_unit_tb.sv
